@@ src/sdar_pkg.sv @@
// Shared types, constants and helpers for the stick direction auto-repeat block.
// No dependencies; every other file refers to it by scoped names.
package sdar_pkg;

  localparam int AXIS_W     = 16;
  localparam int MAG_W      = AXIS_W + 1;
  localparam int DZ_W       = 15;
  localparam int TIME_W     = 22;
  localparam int ELAPSED_W  = 20;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HSUP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VSUP     = 3'd4;

  localparam logic [DZ_W-1:0]   DEADZONE_RST = 15'd16384;
  localparam logic [TIME_W-1:0] DELAY_RST    = 22'd400000;
  localparam logic [TIME_W-1:0] RATE_RST     = 22'd100000;
  localparam logic [TIME_W-1:0] MIN_RATE     = 22'd1000;

  typedef struct packed {
    logic [DZ_W-1:0]   deadzone;
    logic [TIME_W-1:0] repeat_delay;
    logic [TIME_W-1:0] repeat_rate;
    logic              hsup;
    logic              vsup;
  } cfg_t;

  function automatic logic is_suppressed(input logic [DIR_W-1:0] dir, input cfg_t c);
    logic s;
    if (dir == DIR_LEFT || dir == DIR_RIGHT) s = c.hsup;
    else s = c.vsup;
    return s;
  endfunction

endpackage

@@ src/sdar_fifo.sv @@
// Short command queue between the classifier front and the move emitter.
// Depends on sdar_pkg for its depth.
module sdar_fifo #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int DEPTH = sdar_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
`endif

endmodule

@@ src/sdar_front.sv @@
// Front end: accepts samples and ticks, keeps the hold state and timer,
// divides overdue time by the repeat rate, and queues move commands. Uses sdar_pkg.
module sdar_front #(
  parameter int MAX_MOVES = 64,
  parameter int CNT_W     = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sdar_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic signed [sdar_pkg::AXIS_W-1:0] stick_x,
  input  logic signed [sdar_pkg::AXIS_W-1:0] stick_y,
  input  logic                              press_started,
  input  logic [sdar_pkg::ELAPSED_W-1:0]    elapsed,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [sdar_pkg::DIR_W-1:0]        q_dir,
  output logic [CNT_W-1:0]                  q_cnt
);

  localparam int EW       = sdar_pkg::ELAPSED_W;
  localparam int TW       = sdar_pkg::TIME_W;
  localparam int MW       = sdar_pkg::MAG_W;
  localparam int STEP_W   = $clog2(EW);
  localparam int AXIS_MSB = sdar_pkg::AXIS_W - 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } front_state_t;

  front_state_t               st_r, st_nxt;
  logic                       hold_r, hold_nxt;
  logic [sdar_pkg::DIR_W-1:0] dir_r, dir_nxt;
  logic [TW-1:0]              cd_r, cd_nxt;
  logic [EW-1:0]              dvd_r, dvd_nxt;
  logic [TW-1:0]              rem_r, rem_nxt;
  logic [EW-1:0]              quo_r, quo_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;

  logic              accept;
  logic [MW-1:0]     ax, ay;
  logic              released;
  logic [sdar_pkg::DIR_W-1:0] sdir;
  logic [TW:0]       trial;
  logic              trial_ge;

  assign in_ready = (st_r == ST_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // Magnitudes; the most negative code gives 32768.
  assign ax = stick_x[AXIS_MSB] ? (MW'(0) - {stick_x[AXIS_MSB], stick_x})
                                : {1'b0, stick_x};
  assign ay = stick_y[AXIS_MSB] ? (MW'(0) - {stick_y[AXIS_MSB], stick_y})
                                : {1'b0, stick_y};

  assign released = (ax < MW'(cfg.deadzone)) && (ay < MW'(cfg.deadzone));

  always_comb begin
    if (ax > ay) begin
      sdir = (!stick_x[AXIS_MSB] && stick_x != '0) ? sdar_pkg::DIR_RIGHT : sdar_pkg::DIR_LEFT;
    end else begin
      sdir = (!stick_y[AXIS_MSB] && stick_y != '0) ? sdar_pkg::DIR_UP : sdar_pkg::DIR_DOWN;
    end
  end

  // One restoring-division step per cycle.
  assign trial    = {rem_r, dvd_r[EW-1]};
  assign trial_ge = (trial >= {1'b0, cfg.repeat_rate});

  always_comb begin
    st_nxt   = st_r;
    hold_nxt = hold_r;
    dir_nxt  = dir_r;
    cd_nxt   = cd_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    q_push   = 1'b0;
    q_dir    = dir_r;
    q_cnt    = CNT_W'(1);
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (func == sdar_pkg::FUNC_SAMPLE) begin
            if (released) begin
              hold_nxt = 1'b0;
            end else if (press_started || !hold_r || dir_r != sdir) begin
              hold_nxt = 1'b1;
              dir_nxt  = sdir;
              cd_nxt   = cfg.repeat_delay;
              q_dir    = sdir;
              q_push   = !sdar_pkg::is_suppressed(sdir, cfg);
            end
          end else if (hold_r) begin
            if (TW'(elapsed) < cd_r) begin
              cd_nxt = cd_r - TW'(elapsed);
            end else begin
              // Overdue time, divided below to get the periods due.
              dvd_nxt  = EW'(TW'(elapsed) - cd_r);
              rem_nxt  = '0;
              quo_nxt  = '0;
              step_nxt = '0;
              st_nxt   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        dvd_nxt  = {dvd_r[EW-2:0], 1'b0};
        rem_nxt  = trial_ge ? TW'(trial - {1'b0, cfg.repeat_rate}) : trial[TW-1:0];
        quo_nxt  = {quo_r[EW-2:0], trial_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(EW - 1)) begin
          cd_nxt = cfg.repeat_rate - rem_nxt;
          q_dir  = dir_r;
          q_cnt  = (quo_nxt >= EW'(MAX_MOVES)) ? CNT_W'(MAX_MOVES) : CNT_W'(quo_nxt) + 1'b1;
          q_push = !sdar_pkg::is_suppressed(dir_r, cfg);
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      hold_r <= 1'b0;
      dir_r  <= sdar_pkg::DIR_UP;
      cd_r   <= '0;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      hold_r <= hold_nxt;
      dir_r  <= dir_nxt;
      cd_r   <= cd_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

endmodule

@@ src/sdar_back.sv @@
// Back end: takes move commands from the queue and plays them out, one move
// per transfer, flagging the final move of each command. Uses sdar_pkg.
module sdar_back #(
  parameter int CNT_W = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [sdar_pkg::DIR_W-1:0] q_dir,
  input  logic [CNT_W-1:0]           q_cnt,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sdar_pkg::DIR_W-1:0] out_dir,
  output logic                       out_last
);

  logic                       act_r, act_nxt;
  logic [sdar_pkg::DIR_W-1:0] dir_r, dir_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       xfer, load;

  assign out_valid = act_r;
  assign out_dir   = dir_r;
  assign out_last  = (cnt_r == CNT_W'(1));
  assign xfer      = act_r && out_ready;
  assign load      = q_valid && (!act_r || (xfer && out_last));
  assign q_pop     = load;

  always_comb begin
    act_nxt = act_r;
    dir_nxt = dir_r;
    cnt_nxt = cnt_r;
    if (load) begin
      act_nxt = 1'b1;
      dir_nxt = q_dir;
      cnt_nxt = q_cnt;
    end else if (xfer) begin
      cnt_nxt = cnt_r - 1'b1;
      if (out_last) act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r <= dir_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> cnt_r != '0)
    else $error("active command with zero moves left");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && out_last && !q_valid) |=> !out_valid)
    else $error("move shown after final move with empty queue");
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !out_last) |=> out_valid && $stable(dir_r))
    else $error("run of moves broken before its final move");
`endif

endmodule

@@ src/stick_direction_auto_repeat_unit.sv @@
// Top level of the stick direction auto-repeat block: configuration
// registers, front classifier, command queue and move emitter. Uses sdar_pkg.
//
// Usage:
//   Input channel (in_*): one transfer is either a stick sample (in_tuser = 0)
//   or a time tick (in_tuser = 1). A sample may take or release the held
//   direction and then yields at most one move; a tick advances the repeat
//   timer and yields up to MAX_MOVES_PER_TICK moves of the held direction.
//   Output channel (out_*): one transfer per move, out_tlast high on the
//   final move caused by one input transfer.
//   Configuration (cfg_*): write only while the block is idle.
// Flow:
//   A sample that yields a move pushes one command into the queue; the back end
//   loads it into its registers and shows the move. A tick with periods due runs
//   a restoring divider, one quotient bit per cycle, and in_tready stays low while
//   it divides. The front accepts a sample every cycle while the queue has room;
//   moves leave at one per cycle while out_tready is high. A two-entry command queue decouples both sides.
// Reset: configuration registers return to their defaults and nothing is held.
// Stall: when out_tready is low the current move holds; the front keeps
//   accepting until the queue fills, then drops in_tready.
module stick_direction_auto_repeat_unit #(
  parameter int MAX_MOVES_PER_TICK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: stick_x[15:0], stick_y[31:16], press_started[32], elapsed[52:33]
  input  logic [55:0] in_tdata,
  // in_tuser: func[0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: move_direction[1:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic                                cfg_we,
  input  logic [sdar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdar_pkg::TIME_W-1:0]         cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_MOVES_PER_TICK + 1);
  localparam int DW    = sdar_pkg::DIR_W;
  localparam int QW    = DW + CNT_W;

  sdar_pkg::cfg_t cfg_r, cfg_nxt;

  // Register writes; clamp the repeat rate to its floor.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sdar_pkg::REG_DEADZONE: cfg_nxt.deadzone     = cfg_wdata[sdar_pkg::DZ_W-1:0];
        sdar_pkg::REG_DELAY:    cfg_nxt.repeat_delay = cfg_wdata;
        sdar_pkg::REG_RATE: begin
          cfg_nxt.repeat_rate = (cfg_wdata < sdar_pkg::MIN_RATE) ? sdar_pkg::MIN_RATE
                                                                  : cfg_wdata;
        end
        sdar_pkg::REG_HSUP:     cfg_nxt.hsup = cfg_wdata[0];
        sdar_pkg::REG_VSUP:     cfg_nxt.vsup = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone     <= sdar_pkg::DEADZONE_RST;
      cfg_r.repeat_delay <= sdar_pkg::DELAY_RST;
      cfg_r.repeat_rate  <= sdar_pkg::RATE_RST;
      cfg_r.hsup         <= 1'b0;
      cfg_r.vsup         <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic          q_push, q_pop, q_full, q_valid;
  logic [DW-1:0] push_dir, q_dir, out_dir;
  logic [CNT_W-1:0] push_cnt, q_cnt;
  logic [QW-1:0] q_rdata;

  sdar_front #(
    .MAX_MOVES (MAX_MOVES_PER_TICK),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .func          (in_tuser),
    .stick_x       (in_tdata[15:0]),
    .stick_y       (in_tdata[31:16]),
    .press_started (in_tdata[32]),
    .elapsed       (in_tdata[52:33]),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_dir         (push_dir),
    .q_cnt         (push_cnt)
  );

  sdar_fifo #(
    .W (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({push_dir, push_cnt}),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign q_dir = q_rdata[QW-1:CNT_W];
  assign q_cnt = q_rdata[CNT_W-1:0];

  sdar_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_dir     (q_dir),
    .q_cnt     (q_cnt),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dir   (out_dir),
    .out_last  (out_tlast)
  );

  assign out_tdata = {(8 - DW)'(0), out_dir};

endmodule
